// ===== rtl/tllg_pkg.sv =====
// ----------------------------------------------------------------------------
// tllg_pkg
// Shared types and constants of the track-line local goal block.
// ----------------------------------------------------------------------------
package tllg_pkg;

	// default coordinate format, 1/256 m in 24 bits
	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 8;

	// lead distance register
	localparam int LEAD_BITS  = 23;
	localparam int LEAD_RESET = 256;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_X   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_Y   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEAD    = 3'd4;

	// guidance mode codes
	localparam logic MODE_APPROACH = 1'b0;
	localparam logic MODE_TRANSIT  = 1'b1;

	// line length sequencer
	typedef enum logic [2:0] {
		LS_IDLE,
		LS_SQUARE,
		LS_SUM,
		LS_ROOT,
		LS_ROUND
	} line_state_t;

	// status of the line unit
	typedef struct packed {
		logic busy;
		logic degen;
	} line_stat_t;

endpackage

// ===== rtl/tllg_if.sv =====
// ----------------------------------------------------------------------------
// tllg_if
// Valid/ready channels of the track-line local goal block.
// ----------------------------------------------------------------------------
interface tllg_pos_if import tllg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vehicle_x;
	logic signed [COORD_BITS-1:0] vehicle_y;

	modport source(output valid, output vehicle_x, output vehicle_y, input ready);
	modport sink(input valid, input vehicle_x, input vehicle_y, output ready);
endinterface

interface tllg_goal_if import tllg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] goal_x;
	logic signed [COORD_BITS-1:0] goal_y;
	logic                         guidance_mode;
	logic signed [COORD_BITS-1:0] cross_track_error;
	logic                         line_degenerate;

	modport source(output valid, output goal_x, output goal_y, output guidance_mode,
		output cross_track_error, output line_degenerate, input ready);
	modport sink(input valid, input goal_x, input goal_y, input guidance_mode,
		input cross_track_error, input line_degenerate, output ready);
endinterface

// ===== rtl/tllg_line.sv =====
// ----------------------------------------------------------------------------
// tllg_line
// Configuration registers and line geometry: direction and rounded length,
// the length found by a bit-serial square root after each line write.
// ----------------------------------------------------------------------------
module tllg_line import tllg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [CFG_IDX_BITS-1:0]        cfg_idx,
	input  logic [((COORD_BITS > LEAD_BITS) ? COORD_BITS : LEAD_BITS)-1:0] cfg_wdata,
	output logic signed [COORD_BITS-1:0]   start_x,
	output logic signed [COORD_BITS-1:0]   start_y,
	output logic signed [COORD_BITS-1:0]   end_x,
	output logic signed [COORD_BITS-1:0]   end_y,
	output logic [LEAD_BITS-1:0]           lead,
	output logic signed [COORD_BITS:0]     dir_x,
	output logic signed [COORD_BITS:0]     dir_y,
	output logic [COORD_BITS:0]            line_len,
	output line_stat_t                     stat
);
	localparam int C  = COORD_BITS;
	localparam int SQ = 2 * C + 1;

	line_state_t state_q, state_d;

	logic signed [C-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [LEAD_BITS-1:0] lead_q;
	logic signed [C:0]   dx_q, dy_q;
	logic [C:0]          len_q;
	logic                degen_q;
	logic [2*C-1:0]      sqx_q, sqy_q;
	logic [SQ-1:0]       rem_q, res_q, bit_q;

	logic                line_wr;
	logic signed [C:0]   dxw, dyw;
	logic signed [2*C+1:0] sqx_full, sqy_full;
	logic [SQ:0]         trial;

	// a write to any line end point restarts the geometry
	assign line_wr = cfg_wen && (cfg_idx == REG_START_X || cfg_idx == REG_START_Y ||
		cfg_idx == REG_END_X || cfg_idx == REG_END_Y);

	assign dxw      = (C+1)'(ex_q) - (C+1)'(sx_q);
	assign dyw      = (C+1)'(ey_q) - (C+1)'(sy_q);
	assign sqx_full = dxw * dxw;
	assign sqy_full = dyw * dyw;
	assign trial    = (SQ+1)'(res_q) + (SQ+1)'(bit_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LS_IDLE:   state_d = LS_IDLE;
			LS_SQUARE: state_d = LS_SUM;
			LS_SUM:    state_d = LS_ROOT;
			LS_ROOT:   state_d = bit_q[0] ? LS_ROUND : LS_ROOT;
			LS_ROUND:  state_d = LS_IDLE;
			default:   state_d = LS_IDLE;
		endcase
		if (line_wr) begin
			state_d = LS_SQUARE;
		end
	end

	// registers and root iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q    <= '0;
			sy_q    <= '0;
			ex_q    <= '0;
			ey_q    <= '0;
			lead_q  <= LEAD_BITS'(1) << FRAC_BITS;
			dx_q    <= (C+1)'(1);
			dy_q    <= '0;
			len_q   <= (C+1)'(1);
			degen_q <= 1'b1;
			sqx_q   <= '0;
			sqy_q   <= '0;
			rem_q   <= '0;
			res_q   <= '0;
			bit_q   <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx)
					REG_START_X: sx_q <= cfg_wdata[C-1:0];
					REG_START_Y: sy_q <= cfg_wdata[C-1:0];
					REG_END_X:   ex_q <= cfg_wdata[C-1:0];
					REG_END_Y:   ey_q <= cfg_wdata[C-1:0];
					REG_LEAD:    lead_q <= cfg_wdata[LEAD_BITS-1:0];
					default: ;
				endcase
			end
			case (state_q)
				LS_SQUARE: begin
					sqx_q   <= sqx_full[2*C-1:0];
					sqy_q   <= sqy_full[2*C-1:0];
					degen_q <= (dxw == '0) && (dyw == '0);
					dx_q    <= ((dxw == '0) && (dyw == '0)) ? (C+1)'(1) : dxw;
					dy_q    <= dyw;
				end
				LS_SUM: begin
					rem_q <= SQ'(sqx_q) + SQ'(sqy_q);
					res_q <= '0;
					bit_q <= SQ'(1) << (2 * C);
				end
				LS_ROOT: begin
					if ((SQ+1)'(rem_q) >= trial) begin
						rem_q <= rem_q - trial[SQ-1:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				LS_ROUND: begin
					// round to nearest: step up when the remainder exceeds the root
					len_q <= degen_q ? (C+1)'(1) :
						(C+1)'(res_q + SQ'(rem_q > res_q));
				end
				default: ;
			endcase
		end
	end

	assign start_x    = sx_q;
	assign start_y    = sy_q;
	assign end_x      = ex_q;
	assign end_y      = ey_q;
	assign lead       = lead_q;
	assign dir_x      = dx_q;
	assign dir_y      = dy_q;
	assign line_len   = len_q;
	assign stat.busy  = (state_q != LS_IDLE);
	assign stat.degen = degen_q;

endmodule

// ===== rtl/tllg_div2.sv =====
// ----------------------------------------------------------------------------
// tllg_div2
// Pipelined restoring divider: two signed numerators over one shared divisor,
// one quotient bit per stage, rounded to nearest with halves away from zero.
// ----------------------------------------------------------------------------
module tllg_div2 #(
	parameter int NW = 51,
	parameter int DW = 25,
	parameter int QW = 26,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic signed [NW-1:0] num_a,
	input  logic signed [NW-1:0] num_b,
	input  logic [DW-1:0]       den,
	input  logic [SW-1:0]       side_in,
	output logic                out_valid,
	output logic signed [QW:0]  quo_a,
	output logic signed [QW:0]  quo_b,
	output logic [SW-1:0]       side_out
);
	localparam int MW = ((NW > DW) ? NW : DW) + 1;
	localparam int RW = (MW > DW + QW) ? MW : DW + QW;

	logic          v_s    [QW+1];
	logic [RW-1:0] rem_a_s[QW+1];
	logic [RW-1:0] rem_b_s[QW+1];
	logic [QW-1:0] q_a_s  [QW+1];
	logic [QW-1:0] q_b_s  [QW+1];
	logic          sg_a_s [QW+1];
	logic          sg_b_s [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	logic signed [NW:0] na_x, nb_x, abs_a, abs_b;
	logic signed [QW:0] qa_x, qb_x;
	logic               v_out_q;

	// magnitudes plus half the divisor
	assign na_x  = (NW+1)'(num_a);
	assign nb_x  = (NW+1)'(num_b);
	assign abs_a = na_x[NW] ? -na_x : na_x;
	assign abs_b = nb_x[NW] ? -nb_x : nb_x;

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_a_s[0] <= RW'($unsigned(abs_a)) + RW'(den >> 1);
			rem_b_s[0] <= RW'($unsigned(abs_b)) + RW'(den >> 1);
			q_a_s[0]   <= '0;
			q_b_s[0]   <= '0;
			sg_a_s[0]  <= na_x[NW];
			sg_b_s[0]  <= nb_x[NW];
			den_s[0]   <= den;
			side_s[0]  <= side_in;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 1; k <= QW; k++) begin : g_stage
		localparam int BI = QW - k;
		logic [RW-1:0] trial;
		assign trial = RW'(den_s[k-1]) << BI;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_a_s[k-1] >= trial) begin
					rem_a_s[k] <= rem_a_s[k-1] - trial;
					q_a_s[k]   <= q_a_s[k-1] | (QW'(1) << BI);
				end else begin
					rem_a_s[k] <= rem_a_s[k-1];
					q_a_s[k]   <= q_a_s[k-1];
				end
				if (rem_b_s[k-1] >= trial) begin
					rem_b_s[k] <= rem_b_s[k-1] - trial;
					q_b_s[k]   <= q_b_s[k-1] | (QW'(1) << BI);
				end else begin
					rem_b_s[k] <= rem_b_s[k-1];
					q_b_s[k]   <= q_b_s[k-1];
				end
				sg_a_s[k] <= sg_a_s[k-1];
				sg_b_s[k] <= sg_b_s[k-1];
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// sign restore
	assign qa_x = signed'({1'b0, q_a_s[QW]});
	assign qb_x = signed'({1'b0, q_b_s[QW]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (adv) begin
			v_out_q <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quo_a    <= sg_a_s[QW] ? -qa_x : qa_x;
			quo_b    <= sg_b_s[QW] ? -qb_x : qb_x;
			side_out <= side_s[QW];
		end
	end

	assign out_valid = v_out_q;

endmodule

// ===== rtl/tllg_path.sv =====
// ----------------------------------------------------------------------------
// tllg_path
// Per-item pipeline: offsets, dot and cross products, along-track and
// cross-track division, mode choice, goal products and goal division.
// ----------------------------------------------------------------------------
module tllg_path import tllg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] vehicle_x,
	input  logic signed [COORD_BITS-1:0] vehicle_y,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [LEAD_BITS-1:0]         lead,
	input  logic signed [COORD_BITS:0]   dir_x,
	input  logic signed [COORD_BITS:0]   dir_y,
	input  logic [COORD_BITS:0]          line_len,
	input  logic                         degen,
	output logic                         res_valid,
	output logic signed [COORD_BITS-1:0] goal_x,
	output logic signed [COORD_BITS-1:0] goal_y,
	output logic                         guidance_mode,
	output logic signed [COORD_BITS-1:0] cross_track_error,
	output logic                         line_degenerate
);
	localparam int C  = COORD_BITS;
	localparam int PW = 2 * C + 2;
	localparam int NA = PW + 1;
	localparam int QA = C + 2;
	localparam int FW = ((C + 3 > LEAD_BITS + 1) ? C + 3 : LEAD_BITS + 1) + 1;
	localparam int NB = FW + C + 1;
	localparam int QB = FW;
	localparam int SB = C + 2;
	localparam logic [LEAD_BITS-1:0] LEAD_ONE = LEAD_BITS'(1) << FRAC_BITS;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [C:0]   oex_s1, oey_s1, osx_s1, osy_s1;
	logic signed [PW-1:0] pax_s2, pay_s2, pca_s2, pcb_s2;
	logic signed [NA-1:0] along_s3, cross_s3;

	logic                va_out, deg_a;
	logic signed [QA:0]  xe, err;

	logic [LEAD_BITS-1:0] lead_eff;
	logic signed [FW-1:0] xe_ext, lead_ext, lead2;
	logic                transit;
	logic                err_fits;
	logic signed [C-1:0] err_sat;

	logic signed [FW-1:0] fac_s4;
	logic [C+1:0]        denb_s4, denb_s5;
	logic [SB-1:0]       side_s4, side_s5;
	logic signed [NB-1:0] prx_s5, pry_s5;

	logic signed [QB:0]  qbx, qby;
	logic [SB-1:0]       side_b;
	logic signed [FW+1:0] gx_w, gy_w;
	logic                gx_fits, gy_fits;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= va_out;
			v_s5 <= v_s4;
		end
	end

	// offsets, products and sums
	always_ff @(posedge clk) begin
		if (adv) begin
			oex_s1   <= (C+1)'(end_x) - (C+1)'(vehicle_x);
			oey_s1   <= (C+1)'(end_y) - (C+1)'(vehicle_y);
			osx_s1   <= (C+1)'(start_x) - (C+1)'(vehicle_x);
			osy_s1   <= (C+1)'(start_y) - (C+1)'(vehicle_y);
			pax_s2   <= oex_s1 * dir_x;
			pay_s2   <= oey_s1 * dir_y;
			pca_s2   <= dir_x * osy_s1;
			pcb_s2   <= osx_s1 * dir_y;
			along_s3 <= NA'(pax_s2) + NA'(pay_s2);
			cross_s3 <= NA'(pca_s2) - NA'(pcb_s2);
		end
	end

	// along-track and cross-track distances
	tllg_div2 #(.NW(NA), .DW(C + 1), .QW(QA), .SW(1)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s3),
		.num_a    (along_s3),
		.num_b    (cross_s3),
		.den      (line_len),
		.side_in  (degen),
		.out_valid(va_out),
		.quo_a    (xe),
		.quo_b    (err),
		.side_out (deg_a)
	);

	// mode choice: transit when half the along-track distance exceeds the lead
	assign lead_eff = (lead < LEAD_ONE) ? LEAD_ONE : lead;
	assign xe_ext   = FW'(xe);
	assign lead_ext = FW'(signed'({1'b0, lead_eff}));
	assign lead2    = lead_ext <<< 1;
	assign transit  = xe_ext > lead2;

	// cross-track saturation, zero on a degenerate line
	assign err_fits = (err[QA:C-1] == {(QA-C+2){err[QA]}});
	always_comb begin
		if (deg_a) begin
			err_sat = '0;
		end else if (err_fits) begin
			err_sat = err[C-1:0];
		end else begin
			err_sat = err[QA] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
		end
	end

	// goal factor and divisor; approach halves the step
	always_ff @(posedge clk) begin
		if (adv) begin
			fac_s4  <= transit ? (lead_ext - xe_ext) : -xe_ext;
			denb_s4 <= transit ? (C+2)'(line_len) : {line_len, 1'b0};
			side_s4 <= {transit ? MODE_TRANSIT : MODE_APPROACH, deg_a, err_sat};
			prx_s5  <= fac_s4 * dir_x;
			pry_s5  <= fac_s4 * dir_y;
			denb_s5 <= denb_s4;
			side_s5 <= side_s4;
		end
	end

	// step from the end point toward the goal
	tllg_div2 #(.NW(NB), .DW(C + 2), .QW(QB), .SW(SB)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s5),
		.num_a    (prx_s5),
		.num_b    (pry_s5),
		.den      (denb_s5),
		.side_in  (side_s5),
		.out_valid(res_valid),
		.quo_a    (qbx),
		.quo_b    (qby),
		.side_out (side_b)
	);

	// goal and saturation
	assign gx_w    = (FW+2)'(end_x) + (FW+2)'(qbx);
	assign gy_w    = (FW+2)'(end_y) + (FW+2)'(qby);
	assign gx_fits = (gx_w[FW+1:C-1] == {(FW-C+3){gx_w[FW+1]}});
	assign gy_fits = (gy_w[FW+1:C-1] == {(FW-C+3){gy_w[FW+1]}});

	assign goal_x = gx_fits ? gx_w[C-1:0] :
		(gx_w[FW+1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}});
	assign goal_y = gy_fits ? gy_w[C-1:0] :
		(gy_w[FW+1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}});

	assign guidance_mode     = side_b[C+1];
	assign line_degenerate   = side_b[C];
	assign cross_track_error = side_b[C-1:0];

endmodule

// ===== rtl/track_line_local_goal.sv =====
// ----------------------------------------------------------------------------
// track_line_local_goal
// Track-line guidance: local goal, mode and cross-track error per position.
//
//   channel   dir  kind         payload
//   pos       in   valid/ready  vehicle_x, vehicle_y
//   goal      out  valid/ready  goal_x, goal_y, guidance_mode,
//                               cross_track_error, line_degenerate
//   cfg_*     in   write only   cfg_wen, cfg_idx, cfg_wdata
//
// One item per cycle while the output is not stalled and no line square root runs.
// Both dividers produce one quotient bit per stage.
// A write to a line end point runs the length square root: pos.ready is low
// while it runs. Reset leaves a valid degenerate line.
// A stalled output holds its item while the pipeline closes up its bubbles.
// ----------------------------------------------------------------------------
module track_line_local_goal import tllg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	tllg_pos_if.sink                pos,
	tllg_goal_if.source             goal,
	input  logic                    cfg_wen,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [((COORD_BITS > LEAD_BITS) ? COORD_BITS : LEAD_BITS)-1:0] cfg_wdata
);
	localparam int C = COORD_BITS;

	logic signed [C-1:0] start_x, start_y, end_x, end_y;
	logic [LEAD_BITS-1:0] lead;
	logic signed [C:0]   dir_x, dir_y;
	logic [C:0]          line_len;
	line_stat_t          stat;

	logic                adv, accept;
	logic                res_valid;
	logic signed [C-1:0] res_gx, res_gy, res_xte;
	logic                res_mode, res_degen;

	logic                out_v_q;
	logic signed [C-1:0] gx_q, gy_q, xte_q;
	logic                mode_q, degen_q;

	tllg_line #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.lead     (lead),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.line_len (line_len),
		.stat     (stat)
	);

	// pipeline moves unless a finished item is blocked by a full output
	assign adv       = !res_valid || !out_v_q || goal.ready;
	assign pos.ready = adv && !stat.busy;
	assign accept    = pos.valid && pos.ready;

	tllg_path #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_path (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.in_valid         (accept),
		.vehicle_x        (pos.vehicle_x),
		.vehicle_y        (pos.vehicle_y),
		.start_x          (start_x),
		.start_y          (start_y),
		.end_x            (end_x),
		.end_y            (end_y),
		.lead             (lead),
		.dir_x            (dir_x),
		.dir_y            (dir_y),
		.line_len         (line_len),
		.degen            (stat.degen),
		.res_valid        (res_valid),
		.goal_x           (res_gx),
		.goal_y           (res_gy),
		.guidance_mode    (res_mode),
		.cross_track_error(res_xte),
		.line_degenerate  (res_degen)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || goal.ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || goal.ready) begin
			gx_q    <= res_gx;
			gy_q    <= res_gy;
			xte_q   <= res_xte;
			mode_q  <= res_mode;
			degen_q <= res_degen;
		end
	end

	assign goal.valid             = out_v_q;
	assign goal.goal_x            = gx_q;
	assign goal.goal_y            = gy_q;
	assign goal.guidance_mode     = mode_q;
	assign goal.cross_track_error = xte_q;
	assign goal.line_degenerate   = degen_q;

endmodule

// ===== rtl/tllg_checker.sv =====
// ----------------------------------------------------------------------------
// tllg_checker
// Port-level checks of the track-line local goal block, bound to the top.
// ----------------------------------------------------------------------------
module tllg_checker import tllg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [COORD_BITS-1:0] goal_x,
	input logic signed [COORD_BITS-1:0] cross_track_error,
	input logic                         line_degenerate,
	input logic                         cfg_wen,
	input logic [CFG_IDX_BITS-1:0]      cfg_idx
);

	// a stalled item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	// a stalled item keeps its goal_x
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(goal_x))
		else $error("output goal changed while stalled");

	// line geometry recompute blocks new positions
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen && (cfg_idx == REG_START_X || cfg_idx == REG_START_Y ||
		cfg_idx == REG_END_X || cfg_idx == REG_END_Y) |=> !in_ready)
		else $error("position taken during line recompute");

	// a degenerate line has no cross-track error
	a_degen_xte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_degenerate |-> cross_track_error == '0)
		else $error("cross-track error on degenerate line");

endmodule

bind track_line_local_goal tllg_checker #(.COORD_BITS(COORD_BITS)) u_tllg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (pos.ready),
	.out_valid        (goal.valid),
	.out_ready        (goal.ready),
	.goal_x           (goal.goal_x),
	.cross_track_error(goal.cross_track_error),
	.line_degenerate  (goal.line_degenerate),
	.cfg_wen          (cfg_wen),
	.cfg_idx          (cfg_idx)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the track-line local goal block against a predictor of its own:
// each accepted vehicle position yields one expected goal item, and every
// goal item that leaves the block is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
	import tllg_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int WB = (CB > LEAD_BITS) ? CB : LEAD_BITS;
	localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [CB-1:0] vx;
		logic signed [CB-1:0] vy;
	} pos_item_t;

	typedef struct {
		logic signed [CB-1:0] gx;
		logic signed [CB-1:0] gy;
		logic                 mode;
		logic signed [CB-1:0] xte;
		logic                 degen;
	} goal_item_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [WB-1:0] cfg_wdata;

	tllg_pos_if  #(.COORD_BITS(CB)) pos_ch();
	tllg_goal_if #(.COORD_BITS(CB)) goal_ch();

	track_line_local_goal #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .pos(pos_ch.sink), .goal(goal_ch.source),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// line registers as the block should hold them
	longint line_sx, line_sy, line_ex, line_ey, line_lead;

	pos_item_t  pos_pending[$];
	goal_item_t goal_expected[$];
	int errors;
	int n_sent;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	bit hold_done;
	int cycle_cnt;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint sext_coord(longint v);
		logic [CB-1:0] b;
		b = v[CB-1:0];
		return longint'(signed'(b));
	endfunction

	function automatic logic signed [CB-1:0] sat_coord(longint v);
		if (v > CMAX) v = CMAX;
		if (v < CMIN) v = CMIN;
		return v[CB-1:0];
	endfunction

	// round to nearest, halves away from zero, den > 0
	function automatic longint div_round(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// line length: square root rounded to nearest
	function automatic longint line_length(longint d2);
		longint r;
		longint t;
		r = 0;
		for (int b = 26; b >= 0; b--) begin
			t = r | (64'sd1 <<< b);
			if (t * t <= d2) r = t;
		end
		if (d2 - r * r > r) r++;
		return r;
	endfunction

	// local goal, mode and cross-track error for one position
	function automatic goal_item_t predict_goal(pos_item_t p);
		goal_item_t g;
		longint vx, vy, dx, dy, lead, len, xe, gx, gy, xte;
		bit degen, transit;
		vx = p.vx;
		vy = p.vy;
		dx = line_ex - line_sx;
		dy = line_ey - line_sy;
		lead = (line_lead < (64'sd1 <<< FB)) ? (64'sd1 <<< FB) : line_lead;
		degen = (dx == 0 && dy == 0);
		if (degen) begin
			dx = 1;
			dy = 0;
			len = 1;
			xte = 0;
		end else begin
			len = line_length(dx * dx + dy * dy);
			xte = div_round(dx * (line_sy - vy) - (line_sx - vx) * dy, len);
		end
		xe = div_round((line_ex - vx) * dx + (line_ey - vy) * dy, len);
		transit = xe > 2 * lead;
		if (transit) begin
			gx = line_ex + div_round((lead - xe) * dx, len);
			gy = line_ey + div_round((lead - xe) * dy, len);
		end else begin
			gx = line_ex - div_round(xe * dx, 2 * len);
			gy = line_ey - div_round(xe * dy, 2 * len);
		end
		g.gx = sat_coord(gx);
		g.gy = sat_coord(gy);
		g.mode = transit ? MODE_TRANSIT : MODE_APPROACH;
		g.xte = sat_coord(xte);
		g.degen = degen;
		return g;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
		errors++;
	endtask

	// driver: offers pending positions, predicts each accepted item
	always @(posedge clk) begin
		pos_item_t nxt;
		if (arst_n) begin
			if (pos_ch.valid && pos_ch.ready) begin
				nxt.vx = pos_ch.vehicle_x;
				nxt.vy = pos_ch.vehicle_y;
				goal_expected.push_back(predict_goal(nxt));
				n_sent++;
			end
			if (!(pos_ch.valid && !pos_ch.ready)) begin
				if (pos_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pos_pending.pop_front();
					pos_ch.valid <= 1'b1;
					pos_ch.vehicle_x <= nxt.vx;
					pos_ch.vehicle_y <= nxt.vy;
				end else begin
					pos_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off once, so the pipeline fills and stalls its input
	always @(posedge clk) begin
		if (!hold_done && n_sent >= 300) begin
			hold_cycles <= 300;
			hold_done <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// monitor: checks each goal item against the oldest expectation
	always @(posedge clk) begin
		goal_item_t w;
		if (arst_n) begin
			if (goal_ch.valid && goal_ch.ready) begin
				if (goal_expected.size() == 0) begin
					$display("unexpected goal item at cycle %0d", cycle_cnt);
					errors++;
				end else begin
					w = goal_expected.pop_front();
					if (goal_ch.goal_x !== w.gx) report_mismatch("goal_x", goal_ch.goal_x, w.gx);
					if (goal_ch.goal_y !== w.gy) report_mismatch("goal_y", goal_ch.goal_y, w.gy);
					if (goal_ch.guidance_mode !== w.mode)
						report_mismatch("guidance_mode", goal_ch.guidance_mode, w.mode);
					if (goal_ch.cross_track_error !== w.xte)
						report_mismatch("cross_track_error", goal_ch.cross_track_error, w.xte);
					if (goal_ch.line_degenerate !== w.degen)
						report_mismatch("line_degenerate", goal_ch.line_degenerate, w.degen);
				end
			end
			goal_ch.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycle_cnt);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val[WB-1:0];
		case (idx)
			REG_START_X: line_sx = sext_coord(val);
			REG_START_Y: line_sy = sext_coord(val);
			REG_END_X:   line_ex = sext_coord(val);
			REG_END_Y:   line_ey = sext_coord(val);
			REG_LEAD:    line_lead = val & ((64'sd1 <<< LEAD_BITS) - 1);
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pos_pending.size() > 0 || pos_ch.valid || goal_expected.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic longint clamp_coord(longint v);
		return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
	endfunction

	function automatic longint rand_coord();
		return longint'(signed'($urandom_range(32'h00FF_FFFF, 0) << 8) >>> 8);
	endfunction

	// queue positions: mostly near the line, some anywhere, some at the extremes
	task automatic queue_positions(int n);
		pos_item_t p;
		longint t, px, py;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				t = longint'($urandom_range(1400)) - 200;
				px = line_sx + (line_ex - line_sx) * t / 1024 + $signed($urandom_range(8000)) - 4000;
				py = line_sy + (line_ey - line_sy) * t / 1024 + $signed($urandom_range(8000)) - 4000;
			end else if (pick < 88) begin
				px = rand_coord();
				py = rand_coord();
			end else begin
				px = $urandom_range(1) ? CMAX : CMIN;
				py = $urandom_range(1) ? CMAX : CMIN;
			end
			p.vx = clamp_coord(px);
			p.vy = clamp_coord(py);
			pos_pending.push_back(p);
		end
	endtask

	task automatic set_line(longint sx, longint sy, longint ex, longint ey, longint lead);
		wait_drained();
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_END_X, ex);
		write_reg(REG_END_Y, ey);
		write_reg(REG_LEAD, lead);
	endtask

	// stimulus
	initial begin
		pos_item_t p;
		longint span, bx, by;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = REG_START_X;
		cfg_wdata = '0;
		pos_ch.valid = 1'b0;
		pos_ch.vehicle_x = '0;
		pos_ch.vehicle_y = '0;
		goal_ch.ready = 1'b0;
		errors = 0;
		n_sent = 0;
		hold_cycles = 0;
		hold_done = 1'b0;
		cycle_cnt = 0;
		send_idle_pct = 23;
		recv_idle_pct = 51;
		line_sx = 0;
		line_sy = 0;
		line_ex = 0;
		line_ey = 0;
		line_lead = LEAD_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset line is degenerate: extremes and small values of the position fields
		p.vx = CMAX[CB-1:0]; p.vy = CMIN[CB-1:0]; pos_pending.push_back(p);
		p.vx = CMIN[CB-1:0]; p.vy = CMAX[CB-1:0]; pos_pending.push_back(p);
		p.vx = 0; p.vy = 0; pos_pending.push_back(p);
		p.vx = -1; p.vy = 1; pos_pending.push_back(p);
		p.vx = CMIN[CB-1:0]; p.vy = CMIN[CB-1:0]; pos_pending.push_back(p);

		// longest line, largest lead, extreme positions saturate
		set_line(CMIN, CMIN, CMAX, CMAX, (64'sd1 <<< LEAD_BITS) - 1);
		p.vx = CMIN[CB-1:0]; p.vy = CMAX[CB-1:0]; pos_pending.push_back(p);
		p.vx = CMAX[CB-1:0]; p.vy = CMIN[CB-1:0]; pos_pending.push_back(p);
		p.vx = CMIN[CB-1:0]; p.vy = CMIN[CB-1:0]; pos_pending.push_back(p);
		p.vx = 0; p.vy = 0; pos_pending.push_back(p);

		// lead below one metre, short line, unknown register index ignored
		set_line(0, 0, 40000, -30000, 0);
		write_reg(3'd5, 24'h123456);
		write_reg(3'd7, 24'hFFFFFF);
		p.vx = 0; p.vy = 0; pos_pending.push_back(p);
		p.vx = 39000; p.vy = -29000; pos_pending.push_back(p);
		p.vx = 40000; p.vy = -30000; pos_pending.push_back(p);
		p.vx = 50000; p.vy = 10000; pos_pending.push_back(p);
		set_line(-5, 7, -5, 7, 255);
		p.vx = 100; p.vy = -100; pos_pending.push_back(p);
		p.vx = CMAX[CB-1:0]; p.vy = 0; pos_pending.push_back(p);

		// random lines, idling pattern by phase
		for (int ph = 0; ph < 15; ph++) begin
			if (ph == 5) begin
				send_idle_pct = 51;
				recv_idle_pct = 23;
			end else if (ph == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			span = (ph % 3 == 0) ? 64'sd8388607 : ((ph % 3 == 1) ? 64'sd60000 : 64'sd600);
			bx = rand_coord();
			by = rand_coord();
			if (ph == 7)
				set_line(bx, by, bx, by, 256 + $urandom_range(20000));
			else
				set_line(bx, by,
					clamp_coord(bx + $signed($urandom_range(2 * span)) - span),
					clamp_coord(by + $signed($urandom_range(2 * span)) - span),
					(ph == 4) ? $urandom_range(255) :
					((ph == 12) ? (64'sd1 <<< LEAD_BITS) - 1 : 256 + $urandom_range(30000)));
			queue_positions(88);
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
